// ===== rtl/sorted_priority_queue_unit_defines.svh =====
// Assertion macros used by the checker file of the priority queue.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    // Field widths of the item formats.
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OCC_W      = 5;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 40;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // take the input item and issue the first read
        logic shift;   // move one entry up and read the next one down
        logic place;   // write the new value at the scan position
        logic pop;     // drop the front entry
        logic emit;    // load the output register
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_insert;  // the offered item is an insert
        logic full;
        logic empty;
        logic greater;    // the entry just read is greater than the new value
        logic pos_one;    // the scan has reached the slot after the front
    } spq_sts_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  spq_pkg::spq_sts_t sts,
    output spq_pkg::spq_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_PLACE = 5'b00100,
        ST_POP   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Sequencing of one operation.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start = 1'b1;
                    if (sts.in_insert) begin
                        priority if (sts.full) begin
                            state_next = ST_EMIT;
                        end else if (sts.empty) begin
                            state_next = ST_PLACE;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else if (sts.empty) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_SCAN: begin
                if (sts.greater) begin
                    cmd.shift  = 1'b1;
                    state_next = sts.pos_one ? ST_PLACE : ST_SCAN;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_POP: begin
                cmd.pop    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register holds its item until it is taken.
    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/spq_datapath.sv =====
module spq_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0]  s_value,
    input  spq_pkg::spq_cmd_t                    cmd,
    output spq_pkg::spq_sts_t                    sts,
    output logic signed [spq_pkg::VALUE_W-1:0]  m_removed_value,
    output logic [spq_pkg::STATUS_W-1:0]        m_status,
    output logic [spq_pkg::OCC_W-1:0]           m_occupancy
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Entries sit in a ring: logical slot j lives at head + j, modulo DEPTH.
    logic signed [spq_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [CW-1:0]                       count_reg, count_next;
    logic [AW-1:0]                       head_reg, head_next;
    logic [CW-1:0]                       pos_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  x_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  rd_data_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  res_removed_reg;
    logic [spq_pkg::STATUS_W-1:0]        res_status_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  out_removed_reg;
    logic [spq_pkg::STATUS_W-1:0]        out_status_reg;
    logic [spq_pkg::OCC_W-1:0]           out_occ_reg;

    logic                                in_insert;
    logic                                full;
    logic                                empty;
    logic                                rd_en;
    logic [CW-1:0]                       rd_log;
    logic [AW-1:0]                       rd_addr;
    logic                                wr_en;
    logic [AW-1:0]                       wr_addr;
    logic signed [spq_pkg::VALUE_W-1:0]  wr_data;
    logic [CW+spq_pkg::OCC_W-1:0]        occ_ext;

    // Physical address of a logical slot; the sum stays below twice DEPTH.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] j);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(j);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Status towards the controller.
    assign in_insert = (s_opcode == spq_pkg::OP_INSERT);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb begin
        sts           = '0;
        sts.in_insert = in_insert;
        sts.full      = full;
        sts.empty     = empty;
        sts.greater   = (rd_data_reg > x_reg);
        sts.pos_one   = (pos_reg == CW'(1));
    end

    // Read port: the last held entry for an insert, the front for a remove,
    // then one slot further down for each shift.
    always_comb begin
        rd_en  = 1'b0;
        rd_log = '0;
        if (cmd.start) begin
            if (in_insert) begin
                rd_en  = !full && !empty;
                rd_log = count_reg - CW'(1);
            end else begin
                rd_en  = !empty;
                rd_log = '0;
            end
        end else if (cmd.shift) begin
            rd_en  = !sts.pos_one;
            rd_log = pos_reg - CW'(2);
        end
    end

    assign rd_addr = phys(head_reg, rd_log);

    // Write port: an entry moves up one slot, or the new value lands.
    assign wr_en   = cmd.shift || cmd.place;
    assign wr_addr = phys(head_reg, pos_reg);
    assign wr_data = cmd.shift ? rd_data_reg : x_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Occupancy and ring head.
    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        if (cmd.place) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    assign occ_ext = (CW+spq_pkg::OCC_W)'(count_reg);

    // Operation operands, pending result and output register.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg           <= s_value;
            pos_reg         <= count_reg;
            res_removed_reg <= '0;
            if (in_insert && full) begin
                res_status_reg <= spq_pkg::STATUS_FULL;
            end else if (!in_insert && empty) begin
                res_status_reg <= spq_pkg::STATUS_EMPTY;
            end else begin
                res_status_reg <= spq_pkg::STATUS_DONE;
            end
        end
        if (cmd.shift) begin
            pos_reg <= pos_reg - CW'(1);
        end
        if (cmd.pop) begin
            res_removed_reg <= rd_data_reg;
        end
        if (cmd.emit) begin
            out_removed_reg <= res_removed_reg;
            out_status_reg  <= res_status_reg;
            out_occ_reg     <= occ_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign m_removed_value = out_removed_reg;
    assign m_status        = out_status_reg;
    assign m_occupancy     = out_occ_reg;

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Insert: the scan runs from the last held entry toward the front, and each held entry
// greater than the new value moves up one slot, one shift of the store memory per cycle.
// Remove: one memory read; an insert on full or a remove on empty goes straight to its result.
// A new item is accepted the cycle after its predecessor's result is loaded.
// Reset (aresetn low, synchronous) empties the queue and the output register.
module sorted_priority_queue_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // value [31:0]
    input  logic [spq_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode [0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // removed_value [31:0], occupancy [36:32], zero [39:37]
    output logic [spq_pkg::M_TDATA_W-1:0]     m_tdata,
    // status [1:0]
    output logic [spq_pkg::STATUS_W-1:0]      m_tuser
);

    spq_pkg::spq_cmd_t                   cmd;
    spq_pkg::spq_sts_t                   sts;
    logic signed [spq_pkg::VALUE_W-1:0]  removed_value;
    logic [spq_pkg::OCC_W-1:0]           occupancy;

    // Operation sequencing and output handshake.
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Sorted store and result registers.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_opcode        (s_tuser[0]),
        .s_value         (s_tdata[spq_pkg::VALUE_W-1:0]),
        .cmd             (cmd),
        .sts             (sts),
        .m_removed_value (removed_value),
        .m_status        (m_tuser),
        .m_occupancy     (occupancy)
    );

    // Pack the result item.
    assign m_tdata = {
        (spq_pkg::M_TDATA_W - spq_pkg::VALUE_W - spq_pkg::OCC_W)'(0),
        occupancy,
        removed_value
    };

endmodule

// ===== rtl/spq_checker.sv =====
`include "sorted_priority_queue_unit_defines.svh"

module spq_checker #(
    parameter int unsigned DEPTH = 16
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [spq_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [spq_pkg::STATUS_W-1:0]      m_tuser
);

    localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = DEPTH[spq_pkg::OCC_W-1:0];

    // One operation at a time: the input is closed in the cycle after an item is accepted.
    `SPQ_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input reopened at once")

    // A waiting result item holds still.
    `SPQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

    // A dropped insert reports a full queue and no removed value.
    `SPQ_ASSERT_SAME(a_full_result, aclk, aresetn, m_tvalid && m_tuser == spq_pkg::STATUS_FULL, m_tdata[31:0] == 32'd0 && m_tdata[36:32] == FULL_OCC, "bad full result")

    // A remove on an empty queue reports nothing held.
    `SPQ_ASSERT_SAME(a_empty_result, aclk, aresetn, m_tvalid && m_tuser == spq_pkg::STATUS_EMPTY, m_tdata == '0, "bad empty result")

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
